[design/sitda_pkg.sv]
// sitda_pkg: shared types and constants for the signed integer to decimal text block
// holds the controller state type, the command/status structs and the ASCII constants
// no dependencies
`default_nettype none

package sitda_pkg;

  // ASCII codes used on the result channel
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // width of one packed BCD digit
  localparam int DIGIT_BITS = 4;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the input value, clear the digit register
    logic step;      // one shift/add-3 conversion step
    logic shift;     // drop the top digit, move to the next one
    logic sel_sign;  // present '-' on the result channel
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic conv_done; // all conversion steps done
    logic top_zero;  // current top digit is zero
    logic one_left;  // only one digit remains
    logic neg;       // value was negative
  } dp_status_t;

endpackage : sitda_pkg

`default_nettype wire

[design/sitda_if.sv]
// sitda_if: valid/ready channel interfaces for the input value and the result characters
// the input interface width follows the VALUE_BITS parameter of the block
// no dependencies
`default_nettype none

interface sitda_in_if #(
  parameter int VALUE_BITS = 32
) (
  input wire clk
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface : sitda_in_if

interface sitda_out_if (
  input wire clk
);
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink   (input valid, input text_char, input last, output ready);
endinterface : sitda_out_if

`default_nettype wire

[design/sitda_ctrl.sv]
// sitda_ctrl: sequencing state machine for the decimal text converter
// drives the datapath commands and both channel handshakes
// depends on sitda_pkg
`default_nettype none

module sitda_ctrl
  import sitda_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire        out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (status.conv_done) state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        if (!status.top_zero || status.one_left) begin
          state_nxt = status.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_ready) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && status.one_left) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV: begin
        cmd.step = !status.conv_done;
      end
      ST_SKIP: begin
        cmd.shift = status.top_zero && !status.one_left;
      end
      ST_SIGN: begin
        out_valid    = 1'b1;
        cmd.sel_sign = 1'b1;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.shift = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule : sitda_ctrl

`default_nettype wire

[design/sitda_dp.sv]
// sitda_dp: magnitude shifter, BCD digit register and counters of the converter
// one shift/add-3 step per cycle, then digits leave from the top one per cycle while the result channel is ready
// depends on sitda_pkg
`default_nettype none

module sitda_dp
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [VALUE_BITS-1:0] in_value,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output logic [7:0]            text_char,
  output logic                  last
);

  // enough decimal digits for any VALUE_BITS-bit unsigned magnitude
  localparam int NDIG   = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_W  = NDIG * DIGIT_BITS;
  localparam int STEP_W = $clog2(VALUE_BITS + 1);
  localparam int DCNT_W = $clog2(NDIG + 1);

  logic [VALUE_BITS-1:0] mag_r;
  logic                  neg_r;
  logic [BCD_W-1:0]      bcd_r;
  logic [BCD_W-1:0]      bcd_adj;
  logic [STEP_W-1:0]     step_cnt_r;
  logic [DCNT_W-1:0]     dcnt_r;
  logic [DIGIT_BITS-1:0] top_digit;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] =
          bcd_r[i*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
      end else begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_r[i*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  // magnitude, sign and digit register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= in_value[VALUE_BITS-1];
      mag_r <= in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
      bcd_r <= '0;
    end else if (cmd.step) begin
      bcd_r <= {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
      mag_r <= {mag_r[VALUE_BITS-2:0], 1'b0};
    end else if (cmd.shift) begin
      bcd_r <= {bcd_r[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
    end
  end

  // step and digit counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cnt_r <= '0;
      dcnt_r     <= '0;
    end else if (cmd.load) begin
      step_cnt_r <= STEP_W'(VALUE_BITS);
      dcnt_r     <= DCNT_W'(NDIG);
    end else begin
      if (cmd.step)  step_cnt_r <= step_cnt_r - STEP_W'(1);
      if (cmd.shift) dcnt_r     <= dcnt_r - DCNT_W'(1);
    end
  end

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_BITS];

  // status back to the controller
  assign status.conv_done = (step_cnt_r == '0);
  assign status.top_zero  = (top_digit == '0);
  assign status.one_left  = (dcnt_r == DCNT_W'(1));
  assign status.neg       = neg_r;

  // result character from the registered digit or the sign
  assign text_char = cmd.sel_sign ? CHAR_MINUS : (CHAR_ZERO | {4'h0, top_digit});
  assign last      = status.one_left && !cmd.sel_sign;

endmodule : sitda_dp

`default_nettype wire

[design/signed_int_to_decimal_ascii_top.sv]
// signed_int_to_decimal_ascii_top: signed integer to decimal ASCII text converter
// joins the controller and the datapath to the two valid/ready channels
// depends on sitda_pkg, sitda_if, sitda_ctrl, sitda_dp
//
// Usage:
//   in_ch carries one two's complement value per transaction. out_ch returns
//   its decimal text, one character per transaction, most significant first:
//   '-' for a negative value, then the digits with no leading zeros (zero
//   gives a single '0'). last marks the final character of each run.
//   Sequence: the value is captured, then VALUE_BITS shift/add-3 steps run in
//   the double-dabble digit register (32 at the default), the step count is
//   seen to run out and the leading zero digits are skipped; then one
//   character per cycle while out_ch is ready, '-' first on a negative value.
//   The digit register holds ((VALUE_BITS*1233)>>12)+1 digits (10 at the
//   default). Items are converted one at a time.
//   in_ch.ready is high only when no item is in progress.
//   A stall on out_ch holds the current character and last steady; nothing
//   is lost. Synchronous reset returns the block to idle and drops any run.
`default_nettype none

module signed_int_to_decimal_ascii_top
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input wire        clk,
  input wire        rst_n,
  sitda_in_if.sink   in_ch,
  sitda_out_if.source out_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] text_char;
  logic       last;

  // sequencing
  sitda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // conversion datapath
  sitda_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_ch.value),
    .cmd       (cmd),
    .status    (status),
    .text_char (text_char),
    .last      (last)
  );

  // channel hookup
  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.text_char = text_char;
  assign out_ch.last      = last;

endmodule : signed_int_to_decimal_ascii_top

`default_nettype wire

[design/sitda_checker.sv]
// sitda_checker: port-level assertions for the decimal text converter
// bound to signed_int_to_decimal_ascii_top; depends on sitda_pkg
`default_nettype none

module sitda_checker
  import sitda_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] text_char,
  input wire       last
);

  // a stalled character holds with its last flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(last))
    else $error("result changed while stalled");

  // only a sign or a digit leaves the block
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (text_char == CHAR_MINUS) ||
                  (text_char >= CHAR_ZERO && text_char <= CHAR_ZERO + 8'd9))
    else $error("result is not a sign or digit");

  // an accepted value leaves the input busy and the output silent right after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("input taken or output shown right after accept");

  // the final character frees the input side
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last |=> in_ready && !out_valid)
    else $error("block not idle after final character");

  // a sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && text_char == CHAR_MINUS |-> !last)
    else $error("sign marked as final character");

endmodule : sitda_checker

bind signed_int_to_decimal_ascii_top sitda_checker u_sitda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .text_char (out_ch.text_char),
  .last      (out_ch.last)
);

`default_nettype wire

[sim/signed_int_to_decimal_ascii_top_tb.sv]
// signed_int_to_decimal_ascii_top_tb: self-checking bench for the integer to decimal text converter
// predicts each value's character run and checks every out_ch transaction against it
// depends on sitda_pkg, sitda_if and signed_int_to_decimal_ascii_top
module signed_int_to_decimal_ascii_top_tb;
  import sitda_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS    = 32;
  localparam int RADIX         = 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 430;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_REPORTS   = 10;
  // stretch of cycles where neither side idles
  localparam int CALM_FROM     = 4000;
  localparam int CALM_TO       = 9000;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  sitda_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch (.clk(clk));
  sitda_out_if                           out_ch (.clk(clk));

  signed_int_to_decimal_ascii_top #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic [VALUE_BITS-1:0] pending_values[$];
  text_beat_t            expected_text[$];

  int unsigned cycle_count    = 0;
  int unsigned total_values   = 0;
  int unsigned values_sent    = 0;
  int unsigned negatives_sent = 0;
  int unsigned chars_checked  = 0;
  int unsigned mismatches     = 0;
  logic        calm;

  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  always #6 clk = ~clk;

  // expected character run for one value: sign, then digits of the magnitude
  function automatic void queue_decimal_text(logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] magnitude;
    logic [7:0]            digits[$];
    text_beat_t            beat;
    logic                  negative;
    negative  = value[VALUE_BITS-1];
    magnitude = negative ? (~value + 1'b1) : value;
    if (magnitude == 0)
      digits.push_front(CHAR_ZERO);
    while (magnitude != 0) begin
      digits.push_front(CHAR_ZERO + 8'(magnitude % RADIX));
      magnitude = magnitude / RADIX;
    end
    if (negative) begin
      beat.text_char = CHAR_MINUS;
      beat.last      = 1'b0;
      expected_text.push_back(beat);
      negatives_sent++;
    end
    foreach (digits[i]) begin
      beat.text_char = digits[i];
      beat.last      = (i == digits.size() - 1);
      expected_text.push_back(beat);
    end
  endfunction

  // random value, spread over every text length and both signs
  function automatic logic [VALUE_BITS-1:0] random_value();
    int unsigned           n_digits;
    int unsigned           lo;
    int unsigned           hi;
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(7, 0))
      0, 1: v = $urandom();
      2: begin
        case ($urandom_range(3, 0))
          0: v = '0;
          1: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
          2: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
          default: v = '1;
        endcase
      end
      default: begin
        n_digits = $urandom_range(10, 1);
        lo = 1;
        repeat (n_digits - 1) lo = lo * RADIX;
        hi = (n_digits == 10) ? 32'h7fff_ffff : lo * RADIX - 1;
        v  = $urandom_range(hi, lo);
        if ($urandom_range(1, 0))
          v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(string what, text_beat_t want, logic [7:0] got_char,
                               logic got_last);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] %s: expected char %0d last %0b, got char %0d last %0b",
               $time, what, want.text_char, want.last, got_char, got_last);
  endtask

  // driver: offers queued values, predicts each one on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        queue_decimal_text(in_ch.value);
        values_sent++;
      end
      if (pending_values.size() != 0 && (calm || $urandom_range(99, 0) >= 20)) begin
        in_ch.valid <= 1'b1;
        in_ch.value <= pending_values.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: checks each character transaction against the oldest prediction
  always @(posedge clk) begin : text_monitor
    text_beat_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        chars_checked++;
        if (expected_text.size() == 0) begin
          want = '0;
          flag_mismatch("unexpected character", want, out_ch.text_char, out_ch.last);
        end else begin
          want = expected_text.pop_front();
          if (want.text_char !== out_ch.text_char || want.last !== out_ch.last)
            flag_mismatch("wrong character", want, out_ch.text_char, out_ch.last);
        end
      end
      out_ch.ready <= calm || ($urandom_range(99, 0) >= 20);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d values sent",
               cycle_count, values_sent, total_values);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;

    // directed: zero, one digit, decade edges, extremes, alternating bits
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(-32'sd1);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'd99);
    pending_values.push_back(32'd100);
    pending_values.push_back(-32'sd100);
    pending_values.push_back(32'd1000000);
    pending_values.push_back(32'd999999999);
    pending_values.push_back(-32'sd999999999);
    pending_values.push_back(32'd1000000000);
    pending_values.push_back(32'd1234567890);
    pending_values.push_back(-32'sd1234567890);
    pending_values.push_back(32'h7fff_ffff);
    pending_values.push_back(32'h7fff_fffe);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h8000_0001);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'haaaa_aaaa);
    pending_values.push_back(-32'sd5);
    pending_values.push_back(32'd42);
    pending_values.push_back(32'd0);
    repeat (RANDOM_ITEMS) pending_values.push_back(random_value());
    total_values = pending_values.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all values accepted, all characters seen, then a quiet spell
    while (values_sent < total_values) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_text.size() != 0) begin
      mismatches++;
      $display("%0d expected characters never arrived", expected_text.size());
    end
    $display("converted %0d values (%0d negative), checked %0d characters in %0d cycles",
             values_sent, negatives_sent, chars_checked, cycle_count);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule : signed_int_to_decimal_ascii_top_tb

[filelist.f]
design/sitda_pkg.sv
design/sitda_if.sv
design/sitda_ctrl.sv
design/sitda_dp.sv
design/signed_int_to_decimal_ascii_top.sv
design/sitda_checker.sv
sim/signed_int_to_decimal_ascii_top_tb.sv
